/* design/trpp_pkg.sv */
// Shared types, constants and the sine table for the tilt/rotate/project block.
// No dependencies.
package trpp_pkg;

	localparam int ANGLE_STEPS = 360;
	localparam int QUARTER     = 90;
	localparam int TILT_BIAS   = 17000;
	localparam int TILT_SCALE  = 100;
	localparam int TILT_CENTER = 50;
	// floor(n / 34000) == (n * RECIP_K) >> RECIP_SHIFT for n below 2^23
	localparam logic [24:0] RECIP_K = 25'd32338578;
	localparam int RECIP_SHIFT = 40;
	localparam int ZT_MIN      = -5;
	localparam int OFF_W       = 8;
	localparam int ZOFF_W      = 12;
	localparam int CFG_W       = 12;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Z_OFFSET = 2'd2;

	localparam logic [OFF_W-1:0]  X_OFFSET_RST = 8'd30;
	localparam logic [OFF_W-1:0]  Y_OFFSET_RST = 8'd28;
	localparam logic [ZOFF_W-1:0] Z_OFFSET_RST = 12'd750;

	typedef logic signed [15:0] coef_t;
	typedef coef_t mat_t [9];

	typedef enum logic [1:0] {TOP_IDLE, TOP_TILT, TOP_SEG, TOP_OUT} top_st_t;
	typedef enum logic [2:0] {
		MPH_IDLE, MPH_SCALE, MPH_RECIP, MPH_ANGLE, MPH_SINE, MPH_MUL, MPH_WRITE
	} mph_t;
	typedef enum logic [2:0] {
		LS_IDLE, LS_MUL, LS_SUM, LS_ZT, LS_NUM, LS_START, LS_DIV
	} lane_st_t;

	// round(16384 * sin(deg)), 0..90 degrees
	localparam logic [14:0] QSINE [0:90] = '{
		15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
		15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
		15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
		15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
		15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
		15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
		15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
		15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421, 15'd13583,
		15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466, 15'd14598,
		15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296, 15'd15396,
		15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964,
		15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
		15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
	};

	// a in -360..449 degrees
	function automatic coef_t sine_deg(input logic signed [10:0] a);
		logic signed [10:0] k;
		coef_t v;
		k = a;
		if (a < 0) begin
			k = a + 11'(ANGLE_STEPS);
		end else if (a >= 11'(ANGLE_STEPS)) begin
			k = a - 11'(ANGLE_STEPS);
		end
		if (k < 11'(QUARTER)) begin
			v = coef_t'({1'b0, QSINE[k[6:0]]});
		end else if (k < 11'(2 * QUARTER)) begin
			v = coef_t'({1'b0, QSINE[7'(11'(2 * QUARTER) - k)]});
		end else if (k < 11'(3 * QUARTER)) begin
			v = -coef_t'({1'b0, QSINE[7'(k - 11'(2 * QUARTER))]});
		end else begin
			v = -coef_t'({1'b0, QSINE[7'(11'(ANGLE_STEPS) - k)]});
		end
		return v;
	endfunction

	// Q1.14 product, truncated toward zero
	function automatic coef_t qtrunc(input logic signed [31:0] p);
		logic signed [31:0] b;
		b = p + ((p < 0) ? 32'sd16383 : 32'sd0);
		return coef_t'(b >>> 14);
	endfunction

endpackage

/* design/trpp_div.sv */
// Iterative signed divider, one quotient bit per cycle, 16-bit saturated result.
// Depends on trpp_pkg.
module trpp_div #(
	parameter int NW = 24,
	parameter int DW = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] num,
	input  logic signed [DW-1:0] den,
	output logic                 busy,
	output logic signed [15:0]   quo
);
	import trpp_pkg::*;

	localparam int CNTW = $clog2(NW);

	logic          busy_q;
	logic [CNTW-1:0] cnt_q;
	logic [NW-1:0] dvd_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic          neg_q;
	logic [DW:0]   trial;
	logic          bit_d;
	logic [DW:0]   diff;

	assign trial = {rem_q, dvd_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign bit_d = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNTW'(NW - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= (num < 0) ? NW'(-num) : NW'(num);
			den_q <= (den < 0) ? DW'(-den) : DW'(den);
			rem_q <= '0;
			neg_q <= (num < 0) ^ (den < 0);
		end else if (busy_q) begin
			rem_q <= bit_d ? diff[DW-1:0] : trial[DW-1:0];
			dvd_q <= {dvd_q[NW-2:0], bit_d};
		end
	end

	always_comb begin
		if (neg_q) begin
			quo = (dvd_q > NW'(32768)) ? -16'sd32768 : 16'(-dvd_q);
		end else begin
			quo = (dvd_q > NW'(32767)) ? 16'sd32767 : 16'(dvd_q);
		end
	end

	assign busy = busy_q;
endmodule

/* design/trpp_matrix.sv */
// Tilt-to-angle update and Q1.14 rotation matrix rebuild.
// Depends on trpp_pkg.
module trpp_matrix (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] tilt_x,
	input  logic signed [15:0] tilt_y,
	output logic               busy,
	output trpp_pkg::mat_t     mat
);
	import trpp_pkg::*;

	mph_t ph_q, ph_d;
	logic signed [15:0] tx_q, ty_q;
	logic [22:0]        magx_q, magy_q;
	logic               negx_q, negy_q;
	logic [7:0]         qx_q, qy_q;
	logic signed [9:0]  pitch_q, yaw_q;
	coef_t              s1_q, c1_q, s2_q, c2_q;
	logic signed [31:0] p3_q, p5_q, p6_q, p8_q;
	mat_t               mat_q;
	logic signed [23:0] nx, ny;
	logic [47:0]        rx, ry;
	logic signed [9:0]  stx, sty;
	logic signed [10:0] sump, sumy;
	logic signed [9:0]  wp, wy;

	function automatic logic signed [9:0] wrap(input logic signed [10:0] s);
		logic signed [10:0] w;
		w = s;
		if (s >= 11'(ANGLE_STEPS)) begin
			w = s - 11'(ANGLE_STEPS);
		end else if (s <= -11'(ANGLE_STEPS)) begin
			w = s + 11'(ANGLE_STEPS);
		end
		return 10'(w);
	endfunction

	always_comb begin
		nx   = (24'(tx_q) + 24'(TILT_BIAS)) * 24'(TILT_SCALE);
		ny   = (24'(ty_q) + 24'(TILT_BIAS)) * 24'(TILT_SCALE);
		rx   = 48'(magx_q) * 48'(RECIP_K);
		ry   = 48'(magy_q) * 48'(RECIP_K);
		stx  = (negx_q ? -10'(qx_q) : 10'(qx_q)) - 10'(TILT_CENTER);
		sty  = (negy_q ? -10'(qy_q) : 10'(qy_q)) - 10'(TILT_CENTER);
		sump = 11'(pitch_q) + 11'(stx);
		sumy = 11'(yaw_q) + 11'(sty);
		wp   = wrap(sump);
		wy   = wrap(sumy);
	end

	always_comb begin
		ph_d = ph_q;
		case (ph_q)
			MPH_IDLE:  if (start) ph_d = MPH_SCALE;
			MPH_SCALE: ph_d = MPH_RECIP;
			MPH_RECIP: ph_d = MPH_ANGLE;
			MPH_ANGLE: ph_d = MPH_SINE;
			MPH_SINE:  ph_d = MPH_MUL;
			MPH_MUL:   ph_d = MPH_WRITE;
			MPH_WRITE: ph_d = MPH_IDLE;
			default:   ph_d = MPH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= MPH_IDLE;
			pitch_q <= '0;
			yaw_q   <= '0;
			for (int i = 0; i < 9; i++) begin
				mat_q[i] <= '0;
			end
		end else begin
			ph_q <= ph_d;
			if (ph_q == MPH_ANGLE) begin
				pitch_q <= wp;
				yaw_q   <= wy;
			end
			if (ph_q == MPH_WRITE) begin
				mat_q[0] <= c1_q;
				mat_q[1] <= '0;
				mat_q[2] <= -s1_q;
				mat_q[3] <= qtrunc(p3_q);
				mat_q[4] <= c2_q;
				mat_q[5] <= qtrunc(p5_q);
				mat_q[6] <= qtrunc(p6_q);
				mat_q[7] <= -s2_q;
				mat_q[8] <= qtrunc(p8_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (ph_q)
			MPH_IDLE: begin
				if (start) begin
					tx_q <= tilt_x;
					ty_q <= tilt_y;
				end
			end
			MPH_SCALE: begin
				negx_q <= nx < 0;
				negy_q <= ny < 0;
				magx_q <= (nx < 0) ? 23'(-nx) : 23'(nx);
				magy_q <= (ny < 0) ? 23'(-ny) : 23'(ny);
			end
			MPH_RECIP: begin
				qx_q <= rx[RECIP_SHIFT +: 8];
				qy_q <= ry[RECIP_SHIFT +: 8];
			end
			MPH_SINE: begin
				s1_q <= sine_deg(11'(yaw_q));
				c1_q <= sine_deg(11'(yaw_q) + 11'(QUARTER));
				s2_q <= sine_deg(11'(pitch_q));
				c2_q <= sine_deg(11'(pitch_q) + 11'(QUARTER));
			end
			MPH_MUL: begin
				p3_q <= 32'(s1_q) * 32'(s2_q);
				p5_q <= 32'(c1_q) * 32'(s2_q);
				p6_q <= 32'(s1_q) * 32'(c2_q);
				p8_q <= 32'(c1_q) * 32'(c2_q);
			end
			default: begin
			end
		endcase
	end

	assign busy = (ph_q != MPH_IDLE);
	assign mat  = mat_q;
endmodule

/* design/trpp_lane.sv */
// One projection lane: rotates one segment end row by row, forms depth,
// then divides x and y by depth. Depends on trpp_pkg and trpp_div.
module trpp_lane #(
	parameter int COORD_WIDTH = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [COORD_WIDTH-1:0] px,
	input  logic signed [COORD_WIDTH-1:0] py,
	input  logic signed [COORD_WIDTH-1:0] pz,
	input  trpp_pkg::mat_t                mat,
	input  logic [trpp_pkg::OFF_W-1:0]    x_off,
	input  logic [trpp_pkg::OFF_W-1:0]    y_off,
	input  logic [trpp_pkg::ZOFF_W-1:0]   z_off,
	output logic                          busy,
	output logic                          zt_ok,
	output logic signed [15:0]            sx,
	output logic signed [15:0]            sy
);
	import trpp_pkg::*;

	localparam int RW = COORD_WIDTH + 2;
	localparam int PW = COORD_WIDTH + 16;
	localparam int AW = COORD_WIDTH + 18;
	localparam int ZW = ((RW > ZOFF_W + 1) ? RW : ZOFF_W + 1) + 1;
	localparam int NW = (((RW + 8) > (ZW + OFF_W + 1)) ? (RW + 8) : (ZW + OFF_W + 1)) + 1;

	lane_st_t st_q, st_d;
	logic [1:0] row_q;
	logic signed [COORD_WIDTH-1:0] px_q, py_q, pz_q;
	coef_t c0, c1, c2;
	logic signed [PW-1:0] m0_s1, m1_s1, m2_s1;
	logic signed [AW-1:0] acc, accb;
	logic signed [RW-1:0] rv, rx_q, ry_q, rz_q;
	logic signed [ZW-1:0] zt_q;
	logic                 ok_q;
	logic signed [OFF_W:0] offx, offy;
	logic signed [ZW+OFF_W:0] offzx, offzy;
	logic signed [NW-1:0] numx_q, numy_q;
	logic signed [15:0]   sx_q, sy_q, qx, qy;
	logic                 div_go, bx, by;

	always_comb begin
		case (row_q)
			2'd0: begin
				c0 = mat[0]; c1 = mat[1]; c2 = mat[2];
			end
			2'd1: begin
				c0 = mat[3]; c1 = mat[4]; c2 = mat[5];
			end
			default: begin
				c0 = mat[6]; c1 = mat[7]; c2 = mat[8];
			end
		endcase
	end

	always_comb begin
		acc   = AW'(m0_s1) + AW'(m1_s1) + AW'(m2_s1);
		accb  = acc + ((acc < 0) ? AW'(16383) : AW'(0));
		rv    = accb[RW+13:14];
		offx  = $signed({1'b0, x_off});
		offy  = $signed({1'b0, y_off});
		offzx = offx * zt_q;
		offzy = offy * zt_q;
	end

	always_comb begin
		st_d   = st_q;
		div_go = 1'b0;
		case (st_q)
			LS_IDLE:  if (start) st_d = LS_MUL;
			LS_MUL:   st_d = LS_SUM;
			LS_SUM:   st_d = (row_q == 2'd2) ? LS_ZT : LS_MUL;
			LS_ZT:    st_d = LS_NUM;
			LS_NUM:   st_d = LS_START;
			LS_START: begin
				div_go = 1'b1;
				st_d   = LS_DIV;
			end
			LS_DIV:   if (!bx && !by) st_d = LS_IDLE;
			default:  st_d = LS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= LS_IDLE;
			row_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == LS_IDLE) begin
				row_q <= '0;
			end else if (st_q == LS_SUM) begin
				row_q <= row_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			LS_IDLE: begin
				if (start) begin
					px_q <= px;
					py_q <= py;
					pz_q <= pz;
				end
			end
			LS_MUL: begin
				m0_s1 <= PW'(px_q) * PW'(c0);
				m1_s1 <= PW'(py_q) * PW'(c1);
				m2_s1 <= PW'(pz_q) * PW'(c2);
			end
			LS_SUM: begin
				case (row_q)
					2'd0:    rx_q <= rv;
					2'd1:    ry_q <= rv;
					default: rz_q <= rv;
				endcase
			end
			LS_ZT: begin
				zt_q <= ZW'(rz_q) - ZW'($signed({1'b0, z_off}));
			end
			LS_NUM: begin
				ok_q   <= zt_q < ZT_MIN;
				numx_q <= (NW'(rx_q) <<< 8) + NW'(offzx);
				numy_q <= (NW'(ry_q) <<< 8) + NW'(offzy);
			end
			LS_DIV: begin
				if (!bx && !by) begin
					sx_q <= qx;
					sy_q <= qy;
				end
			end
			default: begin
			end
		endcase
	end

	trpp_div #(.NW(NW), .DW(ZW)) u_div_x (
		.clk(clk), .arst_n(arst_n), .start(div_go),
		.num(numx_q), .den(zt_q), .busy(bx), .quo(qx)
	);

	trpp_div #(.NW(NW), .DW(ZW)) u_div_y (
		.clk(clk), .arst_n(arst_n), .start(div_go),
		.num(numy_q), .den(zt_q), .busy(by), .quo(qy)
	);

	assign busy  = (st_q != LS_IDLE);
	assign zt_ok = ok_q;
	assign sx    = sx_q;
	assign sy    = sy_q;
endmodule

/* design/tilt_rotate_perspective_projector.sv */
// Top level: config registers, control sequencer, two projection lanes,
// merge and output register. Depends on trpp_pkg, trpp_matrix, trpp_lane.
//
// Usage: items enter on s_tvalid/s_tready/s_tdata/s_tuser. s_tuser is the
// action: 0 is a tilt sample that updates the angles and rebuilds the
// rotation matrix (no result), 1 is a segment that is rotated and projected
// (one result on m_tvalid/m_tready/m_tdata/m_tuser, m_tuser = segment valid).
// One item is worked on at a time. A tilt item runs the 6-step matrix
// pipeline. For a segment the two lanes run side by side: each rotates its
// end one matrix row at a time, with a multiply step and a sum step per row,
// then two bit-serial dividers (one bit per cycle over the NW-bit
// numerator) finish x and y.
// The result sits in an output register, so a new item is accepted while a
// result waits; a stalled receiver holds the next result's merge and the
// next input. Reset clears angles and matrix (all points then rotate to
// the origin) and loads offsets 30, 28, 750. Config writes act at once.
module tilt_rotate_perspective_projector #(
	parameter int COORD_WIDTH = 11
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// tilt_x, tilt_y, start_x, start_y, start_z, end_x, end_y, end_z, zero pad
	input  logic [((32+6*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	// action
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// screen_start_x, screen_start_y, screen_end_x, screen_end_y
	output logic [63:0]                     m_tdata,
	// segment_valid
	output logic                            m_tuser,
	input  logic                            cfg_wen,
	input  logic [trpp_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [trpp_pkg::CFG_W-1:0]      cfg_data
);
	import trpp_pkg::*;

	localparam int CW = COORD_WIDTH;

	top_st_t st_q, st_d;
	logic [OFF_W-1:0]  x_off_q, y_off_q;
	logic [ZOFF_W-1:0] z_off_q;
	logic              in_acc, mat_go, seg_go, load_out;
	logic              mat_busy, busy_a, busy_b, ok_a, ok_b;
	logic signed [15:0] sxa, sya, sxb, syb;
	mat_t              mat;
	logic              m_tvalid_q, m_tuser_q;
	logic [63:0]       m_tdata_q;
	logic              seg_ok;

	assign s_tready = (st_q == TOP_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign mat_go   = in_acc && !s_tuser;
	assign seg_go   = in_acc && s_tuser;
	assign seg_ok   = ok_a && ok_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_off_q <= X_OFFSET_RST;
			y_off_q <= Y_OFFSET_RST;
			z_off_q <= Z_OFFSET_RST;
		end else if (cfg_wen) begin
			case (cfg_idx)
				REG_X_OFFSET: x_off_q <= cfg_data[OFF_W-1:0];
				REG_Y_OFFSET: y_off_q <= cfg_data[OFF_W-1:0];
				REG_Z_OFFSET: z_off_q <= cfg_data[ZOFF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		st_d     = st_q;
		load_out = 1'b0;
		case (st_q)
			TOP_IDLE: begin
				if (mat_go) st_d = TOP_TILT;
				else if (seg_go) st_d = TOP_SEG;
			end
			TOP_TILT: if (!mat_busy) st_d = TOP_IDLE;
			TOP_SEG:  if (!busy_a && !busy_b) st_d = TOP_OUT;
			TOP_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					st_d     = TOP_IDLE;
				end
			end
			default: st_d = TOP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= TOP_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tuser_q <= seg_ok;
			m_tdata_q <= seg_ok ? {syb, sxb, sya, sxa} : 64'd0;
		end
	end

	trpp_matrix u_matrix (
		.clk(clk), .arst_n(arst_n), .start(mat_go),
		.tilt_x(s_tdata[15:0]), .tilt_y(s_tdata[31:16]),
		.busy(mat_busy), .mat(mat)
	);

	trpp_lane #(.COORD_WIDTH(CW)) u_lane_a (
		.clk(clk), .arst_n(arst_n), .start(seg_go),
		.px(s_tdata[32 +: CW]), .py(s_tdata[32+CW +: CW]), .pz(s_tdata[32+2*CW +: CW]),
		.mat(mat), .x_off(x_off_q), .y_off(y_off_q), .z_off(z_off_q),
		.busy(busy_a), .zt_ok(ok_a), .sx(sxa), .sy(sya)
	);

	trpp_lane #(.COORD_WIDTH(CW)) u_lane_b (
		.clk(clk), .arst_n(arst_n), .start(seg_go),
		.px(s_tdata[32+3*CW +: CW]), .py(s_tdata[32+4*CW +: CW]),
		.pz(s_tdata[32+5*CW +: CW]),
		.mat(mat), .x_off(x_off_q), .y_off(y_off_q), .z_off(z_off_q),
		.busy(busy_b), .zt_ok(ok_b), .sx(sxb), .sy(syb)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

	// no unit is still working once the sequencer is back at idle
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == TOP_IDLE) |-> (!mat_busy && !busy_a && !busy_b))
		else $error("unit busy while sequencer idle");

	// a rejected segment carries zero coordinates
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == 64'd0))
		else $error("invalid segment with nonzero coordinates");

	// a tilt item takes the sequencer into the matrix update
	a_tilt_path: assert property (@(posedge clk) disable iff (!arst_n)
		mat_go |=> (st_q == TOP_TILT))
		else $error("tilt item did not enter matrix update");

	// results are only loaded after both lanes finished
	a_merge: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!busy_a && !busy_b))
		else $error("merge while a lane is busy");
endmodule

/* tb/tb_trpp_checker.sv */
// Checker for tilt_rotate_perspective_projector: tracks angles, matrix and offsets,
// predicts each projected segment and compares it with the output stream.
// Depends on trpp_pkg (sine table, register indexes).
module tb_trpp_checker #(
	parameter int COORD_WIDTH = 11,
	parameter int DW = ((32+6*COORD_WIDTH+7)/8)*8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [DW-1:0]                   s_tdata,
	input  logic                            s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [63:0]                     m_tdata,
	input  logic                            m_tuser,
	input  logic                            cfg_wen,
	input  logic [trpp_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [trpp_pkg::CFG_W-1:0]      cfg_data,
	output int                              fail_count,
	output int                              pending
);
	import trpp_pkg::*;

	typedef struct packed {
		logic        seg_ok;
		logic [15:0] sx;
		logic [15:0] sy;
		logic [15:0] ex;
		logic [15:0] ey;
	} screen_seg_t;

	screen_seg_t seg_q[$];
	longint xoff, yoff, zoff;
	longint pitch, yaw;
	longint mat[9];

	assign pending = seg_q.size();

	function automatic longint deg_sin(longint a);
		longint k;
		k = a % ANGLE_STEPS;
		if (k < 0) begin
			k += ANGLE_STEPS;
		end
		case (k / QUARTER)
			0: return longint'(QSINE[k % QUARTER]);
			1: return longint'(QSINE[QUARTER - k % QUARTER]);
			2: return -longint'(QSINE[k % QUARTER]);
			default: return -longint'(QSINE[QUARTER - k % QUARTER]);
		endcase
	endfunction

	function automatic longint tilt_to_step(logic signed [15:0] a);
		return ((longint'(a) + TILT_BIAS) * TILT_SCALE) / 34000 - TILT_CENTER;
	endfunction

	function automatic longint to_screen(longint v, longint off, longint zt);
		longint r;
		r = (256 * v + off * zt) / zt;
		if (r > 32767) begin
			r = 32767;
		end else if (r < -32768) begin
			r = -32768;
		end
		return r;
	endfunction

	task automatic apply_tilt(logic [DW-1:0] d);
		longint s1, c1, s2, c2;
		pitch = (pitch + tilt_to_step(d[15:0])) % ANGLE_STEPS;
		yaw = (yaw + tilt_to_step(d[31:16])) % ANGLE_STEPS;
		s1 = deg_sin(yaw);
		c1 = deg_sin(yaw + QUARTER);
		s2 = deg_sin(pitch);
		c2 = deg_sin(pitch + QUARTER);
		mat[0] = c1;            mat[1] = 0;   mat[2] = -s1;
		mat[3] = s1 * s2 / 16384; mat[4] = c2; mat[5] = c1 * s2 / 16384;
		mat[6] = s1 * c2 / 16384; mat[7] = -s2; mat[8] = c1 * c2 / 16384;
	endtask

	task automatic predict_segment(logic [DW-1:0] d);
		longint p[6];
		longint r[2][3];
		longint zt0, zt1;
		screen_seg_t s;
		for (int i = 0; i < 6; i++) begin
			p[i] = longint'($signed(d[32 + i*COORD_WIDTH +: COORD_WIDTH]));
		end
		for (int e = 0; e < 2; e++) begin
			for (int i = 0; i < 3; i++) begin
				r[e][i] = (p[e*3]*mat[i*3] + p[e*3+1]*mat[i*3+1] + p[e*3+2]*mat[i*3+2])
					/ 16384;
			end
		end
		zt0 = r[0][2] - zoff;
		zt1 = r[1][2] - zoff;
		s = '0;
		if (zt0 < ZT_MIN && zt1 < ZT_MIN) begin
			s.seg_ok = 1'b1;
			s.sx = 16'(to_screen(r[0][0], xoff, zt0));
			s.sy = 16'(to_screen(r[0][1], yoff, zt0));
			s.ex = 16'(to_screen(r[1][0], xoff, zt1));
			s.ey = 16'(to_screen(r[1][1], yoff, zt1));
		end
		seg_q.push_back(s);
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		screen_seg_t w;
		if (!arst_n) begin
			xoff = X_OFFSET_RST;
			yoff = Y_OFFSET_RST;
			zoff = Z_OFFSET_RST;
			pitch = 0;
			yaw = 0;
			for (int i = 0; i < 9; i++) begin
				mat[i] = 0;
			end
			seg_q.delete();
		end else begin
			if (cfg_wen) begin
				case (cfg_idx)
					REG_X_OFFSET: xoff = cfg_data[OFF_W-1:0];
					REG_Y_OFFSET: yoff = cfg_data[OFF_W-1:0];
					REG_Z_OFFSET: zoff = cfg_data[ZOFF_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (seg_q.size() == 0) begin
					report_mismatch("unexpected item, m_tdata low word", m_tdata[15:0], 0);
				end else begin
					w = seg_q.pop_front();
					if (m_tuser !== w.seg_ok)
						report_mismatch("segment_valid", m_tuser, w.seg_ok);
					if (m_tdata[15:0] !== w.sx)
						report_mismatch("screen_start_x", $signed(m_tdata[15:0]), $signed(w.sx));
					if (m_tdata[31:16] !== w.sy)
						report_mismatch("screen_start_y", $signed(m_tdata[31:16]), $signed(w.sy));
					if (m_tdata[47:32] !== w.ex)
						report_mismatch("screen_end_x", $signed(m_tdata[47:32]), $signed(w.ex));
					if (m_tdata[63:48] !== w.ey)
						report_mismatch("screen_end_y", $signed(m_tdata[63:48]), $signed(w.ey));
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser) begin
					predict_segment(s_tdata);
				end else begin
					apply_tilt(s_tdata);
				end
			end
		end
	end

endmodule

/* tb/tb_tilt_rotate_perspective_projector.sv */
// Stimulus and verdict for tilt_rotate_perspective_projector.
// Depends on trpp_pkg, the block and tb_trpp_checker.
module tb_tilt_rotate_perspective_projector;
	import trpp_pkg::*;

	localparam int CW = 11;
	localparam int DW = ((32+6*CW+7)/8)*8;
	localparam int FW = 32 + 6*CW;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic ACT_TILT = 1'b0;
	localparam logic ACT_SEG  = 1'b1;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE = 60;

	logic clk, arst_n;
	logic s_tvalid, s_tready, s_tuser;
	logic [DW-1:0] s_tdata;
	logic m_tvalid, m_tready, m_tuser;
	logic [63:0] m_tdata;
	logic cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_data;
	int fail_count, pending;
	int cycles;
	bit no_idle;
	int hold_req;
	int rx_wait;

	tilt_rotate_perspective_projector #(.COORD_WIDTH(CW)) dut (.*);

	tb_trpp_checker #(.COORD_WIDTH(CW)) chk (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// receiver: per-item stall, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		int w;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait = 0;
		end else if (hold_req > 0) begin
			hold_req--;
			m_tready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			m_tready <= 1'b0;
		end else if (m_tready && m_tvalid) begin
			w = no_idle ? 0 : $urandom_range(0, 7);
			if (w > 0) begin
				m_tready <= 1'b0;
				rx_wait = w - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_item(logic act, logic [FW-1:0] f);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= DW'(f);
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic logic [FW-1:0] rand_fields();
		return FW'({$urandom(), $urandom(), $urandom(), $urandom()});
	endfunction

	function automatic logic [FW-1:0] tilt_fields(logic signed [15:0] tx, logic signed [15:0] ty);
		logic [FW-1:0] f;
		f = rand_fields();
		f[31:0] = {ty, tx};
		return f;
	endfunction

	function automatic logic [FW-1:0] seg_fields(int sx, int sy, int sz, int ex, int ey, int ez);
		logic [FW-1:0] f;
		f = rand_fields();
		f[FW-1:32] = {CW'(ez), CW'(ey), CW'(ex), CW'(sz), CW'(sy), CW'(sx)};
		return f;
	endfunction

	// drain outstanding results and let any tilt update finish
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= CFG_W'(val);
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_offsets(int xo, int yo, int zo);
		drain();
		write_reg(REG_X_OFFSET, xo);
		write_reg(REG_Y_OFFSET, yo);
		write_reg(REG_Z_OFFSET, zo);
		@(posedge clk);
	endtask

	initial begin
		int c;
		s_tvalid = 0;
		s_tuser = 0;
		s_tdata = '0;
		cfg_wen = 0;
		cfg_idx = '0;
		cfg_data = '0;
		hold_req = 0;
		no_idle = 0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// zero matrix: everything rotates to the origin and lands at the offsets
		send_item(ACT_SEG, seg_fields(1023, -1024, 1023, -1024, 1023, -1024));
		send_item(ACT_SEG, seg_fields(0, 0, 0, 5, -5, 7));
		// viewer at the origin with a zero matrix: never in front
		set_offsets(0, 0, 0);
		send_item(ACT_SEG, seg_fields(100, 200, 300, -100, -200, -300));
		// near viewer for saturation, then an ignored register index
		set_offsets(255, 255, 6);
		write_reg(REG_UNUSED, 4095);
		// tilt extremes, including dead center and both +-17000 points
		send_item(ACT_TILT, tilt_fields(-16'sd32768, 16'sd32767));
		send_item(ACT_SEG, seg_fields(1023, 1023, -1024, -1024, -1024, -1024));
		send_item(ACT_TILT, tilt_fields(16'sd0, 16'sd0));
		send_item(ACT_TILT, tilt_fields(-16'sd17000, 16'sd17000));
		send_item(ACT_SEG, seg_fields(-1024, 1023, 1023, 1023, -1024, 10));
		send_item(ACT_TILT, tilt_fields(16'sd32767, -16'sd32768));
		send_item(ACT_SEG, seg_fields(1023, -1024, 0, 0, 1023, -1024));
		send_item(ACT_TILT, tilt_fields(16'sd16999, -16'sd17001));
		send_item(ACT_SEG, seg_fields(3, 4, -5, -6, 7, 8));
		set_offsets(30, 28, 4095);
		send_item(ACT_SEG, seg_fields(1023, 1023, 1023, -1024, -1024, -1024));
		send_item(ACT_SEG, seg_fields(0, 0, 0, 0, 0, 0));

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: set_offsets(30, 28, 750);
				1: set_offsets(0, 0, 0);
				2: set_offsets(255, 255, 4095);
				3: set_offsets(0, 255, 8);
				4: set_offsets($urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 4095));
				5: set_offsets($urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(200, 1500));
				default: set_offsets(255, 0, 1200);
			endcase
			no_idle = (ph == 3);
			for (int i = 0; i < 250; i++) begin
				if (ph == 2 && i == 40) begin
					hold_req = 300;
				end
				if (ph == 5 && i == 100) begin
					// sender waits for the block to empty
					drain();
				end
				c = $urandom_range(0, 3);
				if (c == 0) begin
					send_item(ACT_TILT, rand_fields());
				end else if (c == 1) begin
					send_item(ACT_SEG, seg_fields($urandom_range(0, 400) - 200,
						$urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
						$urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
						$urandom_range(0, 400) - 200));
				end else begin
					send_item(ACT_SEG, rand_fields());
				end
			end
		end
		no_idle = 0;

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
